/* rtl/bdq_pkg.sv */
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded double-ended queue unit.
// ----------------------------------------------------------------------------
package bdq_pkg;

   localparam int DATA_W            = 32;
   localparam int CAP_W             = 11;
   localparam int OPCODE_W          = 3;
   localparam int MAX_DEPTH_DEFAULT = 1024;

   // Stream payload widths, padded to whole bytes.
   localparam int REQ_W = 40;
   localparam int RSP_W = 72;

   localparam logic [CAP_W-1:0]  CAPACITY_RESET = 11'd1024;
   localparam logic [DATA_W-1:0] EMPTY_MARK     = 32'hFFFF_FFFF;

   localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_QUERY      = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;      // accept the request and run the operation
      logic merge;     // fold read data into the cached end values
      logic out_load;  // load the result into the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;  // output register is empty or drains this cycle
   } status_type;

endpackage

/* rtl/bdq_ram.sv */
// ----------------------------------------------------------------------------
// bdq_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/bdq_ctrl.sv */
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer: accept one request, fold in the ring read, hand off the result.
// ----------------------------------------------------------------------------
module bdq_ctrl
   import bdq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.merge = 1'b1;
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/bdq_dpath.sv */
// ----------------------------------------------------------------------------
// bdq_dpath
// Ring store, pointers, count, cached end values and the output register.
// ----------------------------------------------------------------------------
module bdq_dpath
   import bdq_pkg::*;
#(
   parameter int MAX_DEPTH = MAX_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output status_type       status,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             csr_valid,
   input  logic [CAP_W-1:0] csr_data,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata
);

   localparam int PTR_W = $clog2(MAX_DEPTH);
   localparam int CNT_W = $clog2(MAX_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(MAX_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_DEPTH);

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_LAST : p - PTR_W'(1);
   endfunction

   logic [PTR_W-1:0]  front_ptr_ff, front_ptr_in;
   logic [PTR_W-1:0]  rear_ptr_ff, rear_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CAP_W-1:0]  cap_ff;
   logic              rd_front_ff, rd_front_in;
   logic              rd_rear_ff, rd_rear_in;
   logic              ok_ff, ok_in;
   logic [DATA_W-1:0] front_cache_ff, front_cache_in;
   logic [DATA_W-1:0] rear_cache_ff, rear_cache_in;
   logic              rsp_valid_ff;
   logic [RSP_W-1:0]  rsp_data_ff;

   logic [OPCODE_W-1:0] opcode;
   logic [DATA_W-1:0]   value;
   logic                is_full;
   logic                is_empty;
   logic                ram_we;
   logic [PTR_W-1:0]    ram_waddr;
   logic                ram_re;
   logic [PTR_W-1:0]    ram_raddr;
   logic [DATA_W-1:0]   ram_rdata;
   logic [DATA_W-1:0]   front_sel;
   logic [DATA_W-1:0]   rear_sel;

   assign opcode = req_tdata[OPCODE_W-1:0];
   assign value  = req_tdata[OPCODE_W +: DATA_W];

   // A capacity above the ring depth saturates at the depth.
   assign is_full  = (32'(count_ff) >= 32'(cap_ff)) || (count_ff >= CNT_LIMIT);
   assign is_empty = (count_ff == '0);

   assign front_sel = (cmd.merge && rd_front_ff) ? ram_rdata : front_cache_ff;
   assign rear_sel  = (cmd.merge && rd_rear_ff)  ? ram_rdata : rear_cache_ff;

   always_comb begin
      front_ptr_in   = front_ptr_ff;
      rear_ptr_in    = rear_ptr_ff;
      count_in       = count_ff;
      rd_front_in    = rd_front_ff;
      rd_rear_in     = rd_rear_ff;
      ok_in          = ok_ff;
      front_cache_in = front_sel;
      rear_cache_in  = rear_sel;
      ram_we         = 1'b0;
      ram_waddr      = rear_ptr_ff;
      ram_re         = 1'b0;
      ram_raddr      = front_ptr_ff;
      if (cmd.take) begin
         rd_front_in = 1'b0;
         rd_rear_in  = 1'b0;
         ok_in       = 1'b0;
         unique case (opcode)
            OP_PUSH_FRONT: begin
               if (!is_full) begin
                  front_ptr_in   = ptr_prev(front_ptr_ff);
                  ram_we         = 1'b1;
                  ram_waddr      = front_ptr_in;
                  count_in       = count_ff + CNT_W'(1);
                  ok_in          = 1'b1;
                  front_cache_in = value;
                  if (is_empty) begin
                     rear_cache_in = value;
                  end
               end
            end
            OP_PUSH_BACK: begin
               if (!is_full) begin
                  ram_we        = 1'b1;
                  ram_waddr     = rear_ptr_ff;
                  rear_ptr_in   = ptr_next(rear_ptr_ff);
                  count_in      = count_ff + CNT_W'(1);
                  ok_in         = 1'b1;
                  rear_cache_in = value;
                  if (is_empty) begin
                     front_cache_in = value;
                  end
               end
            end
            OP_POP_FRONT: begin
               if (!is_empty) begin
                  front_ptr_in = ptr_next(front_ptr_ff);
                  ram_re       = 1'b1;
                  ram_raddr    = front_ptr_in;
                  rd_front_in  = 1'b1;
                  count_in     = count_ff - CNT_W'(1);
                  ok_in        = 1'b1;
               end
            end
            OP_POP_BACK: begin
               if (!is_empty) begin
                  rear_ptr_in = ptr_prev(rear_ptr_ff);
                  ram_re      = 1'b1;
                  ram_raddr   = ptr_prev(rear_ptr_in);
                  rd_rear_in  = 1'b1;
                  count_in    = count_ff - CNT_W'(1);
                  ok_in       = 1'b1;
               end
            end
            OP_QUERY: begin
               ok_in = 1'b1;
            end
            default: begin
               ok_in = 1'b0;
            end
         endcase
      end
   end

   bdq_ram #(
      .WIDTH(DATA_W),
      .DEPTH(MAX_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(value),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ptr_ff <= '0;
         rear_ptr_ff  <= '0;
         count_ff     <= '0;
         cap_ff       <= CAPACITY_RESET;
         rd_front_ff  <= 1'b0;
         rd_rear_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ptr_ff <= front_ptr_in;
         rear_ptr_ff  <= rear_ptr_in;
         count_ff     <= count_in;
         rd_front_ff  <= rd_front_in;
         rd_rear_ff   <= rd_rear_in;
         if (csr_valid) begin
            cap_ff <= csr_data;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ok_ff          <= ok_in;
      front_cache_ff <= front_cache_in;
      rear_cache_ff  <= rear_cache_in;
      if (cmd.out_load) begin
         rsp_data_ff <= {
            5'b0,
            is_full,
            is_empty,
            is_empty ? EMPTY_MARK : rear_sel,
            is_empty ? EMPTY_MARK : front_sel,
            ok_ff
         };
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;

endmodule

/* rtl/bounded_double_ended_queue_unit.sv */
// A result is registered in the merge state, or later in the hold state while
// the output register is occupied. The controller accepts a request, then
// merges the ring read, and takes no new request before the result is loaded.
// Reset (synchronous, active high) empties the queue, clears the pointers
// and the output, and sets the capacity to 1024. The ring store is not
// cleared; a value read from an entry that no push wrote is never reported.
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_unit
// Bounded deque of signed 32-bit values held in a ring store.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_unit
   import bdq_pkg::*;
#(
   // Depth of the ring store; the effective capacity never exceeds it.
   parameter int MAX_DEPTH = MAX_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   // Request stream. tdata: opcode [2:0], value [34:3], zero padding.
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   // Result stream. tdata: ok [0], front_value [32:1], rear_value [64:33],
   // is_empty [65], is_full [66], zero padding.
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,
   // Capacity register write channel.
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CAP_W-1:0] csr_data
);

   cmd_type    cmd;
   status_type status;

   // The capacity register takes a write in any cycle. The user must issue
   // writes only while no request is in flight; the block does not enforce it.
   assign csr_ready = 1'b1;

   // The controller walks each request through three steps: the request
   // transfer (pointers, count and pushes are updated at once and a pop
   // issues a ring read), the merge of the read data into the cached end
   // values, and the handoff to the output register. The output register
   // lets the result wait for the consumer while the next request can be
   // accepted.
   bdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath keeps the front and rear values in registers so that a
   // push never needs a read; a pop reads the entry that becomes the new
   // end. An empty queue reports all ones at both ends.
   bdq_dpath #(
      .MAX_DEPTH(MAX_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

endmodule

/* rtl/bdq_checker.sv */
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks of the deque unit, bound to the top level.
// ----------------------------------------------------------------------------
module bdq_checker
   import bdq_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   // A result that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn before transfer");

   // After a request transfer the unit is busy for the next cycle.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // Once an accepted request has passed the merge state, a result is on offer.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> ##2 rsp_tvalid)
      else $error("result missing after request");

   // An empty queue reports all ones at both ends.
   a_empty_mark: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[65] |->
         rsp_tdata[32:1] == EMPTY_MARK && rsp_tdata[64:33] == EMPTY_MARK)
      else $error("empty queue reports an end value");

endmodule

bind bounded_double_ended_queue_unit bdq_checker u_bdq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
